[rtl/http_chunked_body_decoder_defines.svh]
// Assertion macros shared by the checker of the chunked body decoder.
// Depends on nothing; included by files that carry assertions.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HCBD_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HCBD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

[rtl/hcbd_pkg.sv]
// Types, constants and the hex digit decoder of the chunked body decoder.
// Depends on nothing; used by the decoder top level, hcbd_step and hcbd_rsp_buffer.
`default_nettype none

package hcbd_pkg;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_SIZE_LF,
      PH_DATA,
      PH_DATA_CR,
      PH_DATA_LF,
      PH_FINAL_CR,
      PH_FINAL_LF,
      PH_DONE
   } phase_type;

   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_BAD_DIGIT     = 4'd1;
   localparam logic [3:0] ERR_NO_SIZE_LF    = 4'd2;
   localparam logic [3:0] ERR_EMPTY_SIZE    = 4'd3;
   localparam logic [3:0] ERR_NO_DATA_CR    = 4'd4;
   localparam logic [3:0] ERR_NO_DATA_LF    = 4'd5;
   localparam logic [3:0] ERR_NO_FINAL_CR   = 4'd6;
   localparam logic [3:0] ERR_NO_FINAL_LF   = 4'd7;
   localparam logic [3:0] ERR_SIZE_OVERFLOW = 4'd8;

   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   typedef struct packed {
      phase_type  phase;
      logic       digit_seen;
      logic [3:0] error_code;
   } ctrl_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       chunk_last;
      logic       message_done;
      logic       error_flag;
      logic [3:0] error_code;
   } rsp_type;

   // Returns {is_digit, value}.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [7:0] diff;
      logic [4:0] result;
      diff   = 8'd0;
      result = 5'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         diff   = b - CHAR_ZERO;
         result = {1'b1, diff[3:0]};
      end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) begin
         diff   = b - CHAR_LOWER_A;
         result = {1'b1, diff[3:0] + 4'd10};
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         diff   = b - CHAR_UPPER_A;
         result = {1'b1, diff[3:0] + 4'd10};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/hcbd_step.sv]
// Next-state and result logic for one body byte of the chunked decoder.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_step #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic [7:0]             data_byte,
   input  wire logic                   start_message,
   input  wire hcbd_pkg::ctrl_type     ctrl,
   input  wire logic [COUNT_WIDTH-1:0] size_acc,
   input  wire logic [COUNT_WIDTH-1:0] remaining,
   output hcbd_pkg::ctrl_type          ctrl_next,
   output logic [COUNT_WIDTH-1:0]      size_acc_next,
   output logic [COUNT_WIDTH-1:0]      remaining_next,
   output hcbd_pkg::rsp_type           rsp
);

   hcbd_pkg::ctrl_type     cur;
   logic [COUNT_WIDTH-1:0] acc_cur;
   logic [COUNT_WIDTH-1:0] rem_cur;
   logic [COUNT_WIDTH-1:0] rem_dec;
   logic [4:0]             hex;
   logic                   valid;
   logic                   last;

   assign hex     = hcbd_pkg::hex_decode(data_byte);
   assign rem_dec = rem_cur - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      if (start_message) begin
         cur.phase      = hcbd_pkg::PH_SIZE;
         cur.digit_seen = 1'b0;
         cur.error_code = hcbd_pkg::ERR_NONE;
         acc_cur        = '0;
         rem_cur        = '0;
      end else begin
         cur     = ctrl;
         acc_cur = size_acc;
         rem_cur = remaining;
      end

      ctrl_next      = cur;
      size_acc_next  = acc_cur;
      remaining_next = rem_cur;
      valid          = 1'b0;
      last           = 1'b0;

      if (cur.error_code == hcbd_pkg::ERR_NONE) begin
         unique case (cur.phase)
            hcbd_pkg::PH_SIZE: begin
               if (data_byte == hcbd_pkg::CHAR_CR) begin
                  ctrl_next.phase = hcbd_pkg::PH_SIZE_LF;
               end else if (!hex[4]) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_BAD_DIGIT;
               end else if (acc_cur[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_SIZE_OVERFLOW;
               end else begin
                  size_acc_next        = {acc_cur[COUNT_WIDTH-5:0], hex[3:0]};
                  ctrl_next.digit_seen = 1'b1;
               end
            end
            hcbd_pkg::PH_SIZE_LF: begin
               if (data_byte != hcbd_pkg::CHAR_LF) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_NO_SIZE_LF;
               end else if (!cur.digit_seen) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_EMPTY_SIZE;
               end else if (acc_cur == '0) begin
                  ctrl_next.phase = hcbd_pkg::PH_FINAL_CR;
               end else begin
                  remaining_next  = acc_cur;
                  ctrl_next.phase = hcbd_pkg::PH_DATA;
               end
            end
            hcbd_pkg::PH_DATA: begin
               valid          = 1'b1;
               remaining_next = rem_dec;
               if (rem_dec == '0) begin
                  last            = 1'b1;
                  ctrl_next.phase = hcbd_pkg::PH_DATA_CR;
               end
            end
            hcbd_pkg::PH_DATA_CR: begin
               if (data_byte != hcbd_pkg::CHAR_CR) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_NO_DATA_CR;
               end else begin
                  ctrl_next.phase = hcbd_pkg::PH_DATA_LF;
               end
            end
            hcbd_pkg::PH_DATA_LF: begin
               if (data_byte != hcbd_pkg::CHAR_LF) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_NO_DATA_LF;
               end else begin
                  size_acc_next        = '0;
                  ctrl_next.digit_seen = 1'b0;
                  ctrl_next.phase      = hcbd_pkg::PH_SIZE;
               end
            end
            hcbd_pkg::PH_FINAL_CR: begin
               if (data_byte != hcbd_pkg::CHAR_CR) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_NO_FINAL_CR;
               end else begin
                  ctrl_next.phase = hcbd_pkg::PH_FINAL_LF;
               end
            end
            hcbd_pkg::PH_FINAL_LF: begin
               if (data_byte != hcbd_pkg::CHAR_LF) begin
                  ctrl_next.error_code = hcbd_pkg::ERR_NO_FINAL_LF;
               end else begin
                  ctrl_next.phase = hcbd_pkg::PH_DONE;
               end
            end
            hcbd_pkg::PH_DONE: begin
               ctrl_next.phase = hcbd_pkg::PH_DONE;
            end
            default: begin
               ctrl_next.phase = hcbd_pkg::PH_DONE;
            end
         endcase
      end

      rsp.payload_byte  = valid ? data_byte : 8'd0;
      rsp.payload_valid = valid;
      rsp.chunk_last    = last;
      rsp.message_done  = (ctrl_next.phase == hcbd_pkg::PH_DONE);
      rsp.error_flag    = (ctrl_next.error_code != hcbd_pkg::ERR_NONE);
      rsp.error_code    = ctrl_next.error_code;
   end

endmodule

`default_nettype wire

[rtl/hcbd_rsp_buffer.sv]
// Two-entry result buffer that decouples the decoder from the result channel.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_rsp_buffer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire hcbd_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hcbd_pkg::rsp_type      out_data
);

   hcbd_pkg::rsp_type head_ff;
   hcbd_pkg::rsp_type head_in;
   hcbd_pkg::rsp_type tail_ff;
   hcbd_pkg::rsp_type tail_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      unique case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = in_data;
            end else begin
               tail_in = in_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = in_data;
            end else begin
               head_in = tail_ff;
               tail_in = in_data;
            end
         end
         2'b00: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/http_chunked_body_decoder.sv]
// Each result is registered in the result buffer and leaves on the rsp channel behind earlier results.
// Throughput: one body byte per cycle while the result buffer has room; the buffer holds two
// entries, so req_tready stays high while one result waits and drops when both are full.
// Reset (synchronous, active high) returns the parser to the size line, clears any
// error and empties the result buffer. Depends on hcbd_pkg, hcbd_step, hcbd_rsp_buffer.
`default_nettype none

module http_chunked_body_decoder #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] data_byte
   input  wire logic [0:0]  req_tuser,  // [0] start_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] payload_byte, [8] message_done,
                                        // [9] error_flag, [13:10] error_code, [15:14] zero
   output logic [0:0]       rsp_tuser,  // [0] payload_valid
   output logic             rsp_tlast   // chunk_last
);

   hcbd_pkg::ctrl_type     ctrl_ff;
   hcbd_pkg::ctrl_type     ctrl_in;
   logic [COUNT_WIDTH-1:0] size_acc_ff;
   logic [COUNT_WIDTH-1:0] size_acc_in;
   logic [COUNT_WIDTH-1:0] remaining_ff;
   logic [COUNT_WIDTH-1:0] remaining_in;
   hcbd_pkg::rsp_type      step_rsp;
   hcbd_pkg::rsp_type      out_rsp;
   logic                   accept;

   assign accept = req_tvalid && req_tready;

   hcbd_step #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_step (
      .data_byte      (req_tdata),
      .start_message  (req_tuser[0]),
      .ctrl           (ctrl_ff),
      .size_acc       (size_acc_ff),
      .remaining      (remaining_ff),
      .ctrl_next      (ctrl_in),
      .size_acc_next  (size_acc_in),
      .remaining_next (remaining_in),
      .rsp            (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.phase      <= hcbd_pkg::PH_SIZE;
         ctrl_ff.digit_seen <= 1'b0;
         ctrl_ff.error_code <= hcbd_pkg::ERR_NONE;
         size_acc_ff        <= '0;
         remaining_ff       <= '0;
      end else if (accept) begin
         ctrl_ff      <= ctrl_in;
         size_acc_ff  <= size_acc_in;
         remaining_ff <= remaining_in;
      end
   end

   hcbd_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tdata = {2'b00, out_rsp.error_code, out_rsp.error_flag,
                       out_rsp.message_done, out_rsp.payload_byte};
   assign rsp_tuser = out_rsp.payload_valid;
   assign rsp_tlast = out_rsp.chunk_last;

endmodule

`default_nettype wire

[rtl/hcbd_checker.sv]
// Port-level checks on the chunked body decoder, bound to its top level.
// Depends on http_chunked_body_decoder_defines.svh and http_chunked_body_decoder.
`default_nettype none
`include "http_chunked_body_decoder_defines.svh"

module hcbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic unused_req;

   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata) ^ req_tuser[0];

   `HCBD_ASSERT_IMPLY(a_idle_byte_zero, clock, reset, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata[7:0] == 8'd0 && !rsp_tlast)
   `HCBD_ASSERT_IMPLY(a_payload_clean, clock, reset, rsp_tvalid && rsp_tuser[0],
      !rsp_tdata[8] && !rsp_tdata[9])
   `HCBD_ASSERT_IMPLY(a_error_flag_code, clock, reset, rsp_tvalid,
      rsp_tdata[9] == (rsp_tdata[13:10] != 4'd0))
   `HCBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

`default_nettype wire

[dv/http_chunked_body_decoder_tb.sv]
// Self-checking testbench for http_chunked_body_decoder: directed framing cases, then
// random chunked messages with corruption, random idling and one long output stall.
// Depends on hcbd_pkg and the decoder RTL; predicts each result with its own parser model.
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;

   localparam int unsigned ITEM_TARGET = 1450;
   localparam int unsigned QUIET_FROM  = 1250;
   localparam int unsigned CYCLE_LIMIT = 500000;

   class chunk_scoreboard;
      hcbd_pkg::phase_type phase;
      logic [31:0]         size_count;
      logic                have_digit;
      logic [31:0]         left_in_chunk;
      logic [3:0]          err;
      hcbd_pkg::rsp_type   decoded_q[$];
      int unsigned         fail_count;
      int unsigned         decoded_count;

      function new();
         restart();
         fail_count    = 0;
         decoded_count = 0;
      endfunction

      function void restart();
         phase         = hcbd_pkg::PH_SIZE;
         size_count    = '0;
         have_digit    = 1'b0;
         left_in_chunk = '0;
         err           = hcbd_pkg::ERR_NONE;
      endfunction

      // Bit 4 set means the byte is not a hex digit.
      function logic [4:0] nibble_of(logic [7:0] b);
         if (b >= hcbd_pkg::CHAR_ZERO && b <= hcbd_pkg::CHAR_NINE)
            return {1'b0, 4'(b - hcbd_pkg::CHAR_ZERO)};
         if (b >= hcbd_pkg::CHAR_LOWER_A && b <= hcbd_pkg::CHAR_LOWER_F)
            return {1'b0, 4'(b - hcbd_pkg::CHAR_LOWER_A + 10)};
         if (b >= hcbd_pkg::CHAR_UPPER_A && b <= hcbd_pkg::CHAR_UPPER_F)
            return {1'b0, 4'(b - hcbd_pkg::CHAR_UPPER_A + 10)};
         return 5'h10;
      endfunction

      function void note_byte(logic [7:0] b, logic start);
         hcbd_pkg::rsp_type r;
         logic [4:0]        nib;
         r = '0;
         if (start) restart();
         decoded_count++;
         if (err == hcbd_pkg::ERR_NONE) begin
            case (phase)
               hcbd_pkg::PH_SIZE: begin
                  if (b == hcbd_pkg::CHAR_CR) begin
                     phase = hcbd_pkg::PH_SIZE_LF;
                  end else begin
                     nib = nibble_of(b);
                     if (nib[4]) err = hcbd_pkg::ERR_BAD_DIGIT;
                     else if (size_count[31:28] != 4'd0) err = hcbd_pkg::ERR_SIZE_OVERFLOW;
                     else begin
                        size_count = {size_count[27:0], nib[3:0]};
                        have_digit = 1'b1;
                     end
                  end
               end
               hcbd_pkg::PH_SIZE_LF: begin
                  if (b != hcbd_pkg::CHAR_LF) err = hcbd_pkg::ERR_NO_SIZE_LF;
                  else if (!have_digit) err = hcbd_pkg::ERR_EMPTY_SIZE;
                  else if (size_count == '0) phase = hcbd_pkg::PH_FINAL_CR;
                  else begin
                     left_in_chunk = size_count;
                     phase = hcbd_pkg::PH_DATA;
                  end
               end
               hcbd_pkg::PH_DATA: begin
                  r.payload_valid = 1'b1;
                  r.payload_byte  = b;
                  left_in_chunk   = left_in_chunk - 32'd1;
                  if (left_in_chunk == '0) begin
                     r.chunk_last = 1'b1;
                     phase = hcbd_pkg::PH_DATA_CR;
                  end
               end
               hcbd_pkg::PH_DATA_CR: begin
                  if (b != hcbd_pkg::CHAR_CR) err = hcbd_pkg::ERR_NO_DATA_CR;
                  else phase = hcbd_pkg::PH_DATA_LF;
               end
               hcbd_pkg::PH_DATA_LF: begin
                  if (b != hcbd_pkg::CHAR_LF) err = hcbd_pkg::ERR_NO_DATA_LF;
                  else begin
                     size_count = '0;
                     have_digit = 1'b0;
                     phase = hcbd_pkg::PH_SIZE;
                  end
               end
               hcbd_pkg::PH_FINAL_CR: begin
                  if (b != hcbd_pkg::CHAR_CR) err = hcbd_pkg::ERR_NO_FINAL_CR;
                  else phase = hcbd_pkg::PH_FINAL_LF;
               end
               hcbd_pkg::PH_FINAL_LF: begin
                  if (b != hcbd_pkg::CHAR_LF) err = hcbd_pkg::ERR_NO_FINAL_LF;
                  else phase = hcbd_pkg::PH_DONE;
               end
               default: begin
                  phase = hcbd_pkg::PH_DONE;
               end
            endcase
         end
         r.message_done = (phase == hcbd_pkg::PH_DONE);
         r.error_flag   = (err != hcbd_pkg::ERR_NONE);
         r.error_code   = err;
         decoded_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
         if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            fail_count++;
         end
      endfunction

      function void check_result(hcbd_pkg::rsp_type got);
         hcbd_pkg::rsp_type want;
         if (decoded_q.size() == 0) begin
            $error("result item arrived with no byte pending");
            fail_count++;
            return;
         end
         want = decoded_q.pop_front();
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
         compare_field("chunk_last", 8'(want.chunk_last), 8'(got.chunk_last));
         compare_field("message_done", 8'(want.message_done), 8'(got.message_done));
         compare_field("error_flag", 8'(want.error_flag), 8'(got.error_flag));
         compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic [0:0]  req_tuser;   // [0] start_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] payload_byte, [8] message_done, [9] error_flag,
                             // [13:10] error_code, [15:14] zero
   logic [0:0]  rsp_tuser;   // [0] payload_valid
   logic        rsp_tlast;   // chunk_last

   chunk_scoreboard sb;
   logic [7:0]      body[$];
   bit              idle_on = 1'b0;
   bit              long_hold_req = 1'b0;
   int unsigned     cycle_count = 0;

   http_chunked_body_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("http_chunked_body_decoder: mismatch");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic start);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b, start);
   endtask

   // In the text, '<' stands for CR and '>' for LF.
   task automatic send_text(input string t, input logic start);
      logic [7:0] c;
      for (int i = 0; i < t.len(); i++) begin
         c = t[i];
         if (c == "<") c = hcbd_pkg::CHAR_CR;
         else if (c == ">") c = hcbd_pkg::CHAR_LF;
         send_byte(c, start && i == 0);
      end
   endtask

   task automatic push_digit(input int unsigned nib);
      if (nib < 10) body.push_back(8'(hcbd_pkg::CHAR_ZERO + nib));
      else if ($urandom_range(0, 1) == 1) body.push_back(8'(hcbd_pkg::CHAR_UPPER_A + nib - 10));
      else body.push_back(8'(hcbd_pkg::CHAR_LOWER_A + nib - 10));
   endtask

   task automatic push_size(input int unsigned v);
      int unsigned n;
      n = 1;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) push_digit(0);
      while ((v >> (4 * n)) != 0 && n < 8) n++;
      for (int i = n - 1; i >= 0; i--) push_digit((v >> (4 * i)) & 4'hF);
      body.push_back(hcbd_pkg::CHAR_CR);
      body.push_back(hcbd_pkg::CHAR_LF);
   endtask

   task automatic build_body();
      int unsigned pick, len, pos;
      body.delete();
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
         push_digit($urandom_range(1, 15));
         repeat ($urandom_range(8, 9)) push_digit($urandom_range(0, 15));
         body.push_back(hcbd_pkg::CHAR_CR);
         body.push_back(hcbd_pkg::CHAR_LF);
      end else begin
         repeat ($urandom_range(0, 4)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
            push_size(len);
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            body.push_back(hcbd_pkg::CHAR_CR);
            body.push_back(hcbd_pkg::CHAR_LF);
         end
         push_size(0);
         body.push_back(hcbd_pkg::CHAR_CR);
         body.push_back(hcbd_pkg::CHAR_LF);
         if (pick <= 5) begin
            if ($urandom_range(0, 1) == 1) pos = body.size() - 1 - $urandom_range(0, 3);
            else pos = $urandom_range(0, body.size() - 1);
            body[pos] = 8'($urandom_range(0, 255));
         end else if (pick == 6) begin
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic send_body();
      bit skip_start;
      skip_start = ($urandom_range(0, 15) == 0);
      for (int i = 0; i < body.size(); i++)
         send_byte(body[i], (i == 0 && !skip_start) || $urandom_range(0, 299) == 0);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         int unsigned       hold_left;
         hcbd_pkg::rsp_type got;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.payload_byte  = rsp_tdata[7:0];
            got.message_done  = rsp_tdata[8];
            got.error_flag    = rsp_tdata[9];
            got.error_code    = rsp_tdata[13:10];
            got.payload_valid = rsp_tuser[0];
            got.chunk_last    = rsp_tlast;
            sb.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      bit long_hold_done;
      sb = new();
      long_hold_done = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Leading zero, extreme payload, last chunk, then a byte ignored after done.
      send_text("01<>", 1'b1);
      send_byte(8'hFF, 1'b0);
      send_text("<>0<><>", 1'b0);
      send_byte(8'h00, 1'b0);
      // Bad size digit, then a byte ignored while the error is held.
      send_text("g", 1'b1);
      send_byte(8'h00, 1'b0);
      send_text("<>", 1'b1);
      send_text("<x", 1'b1);
      send_text("fEdCbA987", 1'b1);

      while (sb.decoded_count < ITEM_TARGET) begin
         idle_on = ($urandom_range(0, 3) != 0) && (sb.decoded_count < QUIET_FROM);
         if (!long_hold_done && sb.decoded_count > 500) begin
            long_hold_req  = 1'b1;
            long_hold_done = 1'b1;
         end
         build_body();
         send_body();
      end
      idle_on = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0) $display("http_chunked_body_decoder: match");
      else $display("http_chunked_body_decoder: mismatch");
      $finish;
   end

endmodule

[http_chunked_body_decoder.f]
+incdir+rtl
rtl/hcbd_pkg.sv
rtl/hcbd_step.sv
rtl/hcbd_rsp_buffer.sv
rtl/http_chunked_body_decoder.sv
rtl/hcbd_checker.sv
dv/http_chunked_body_decoder_tb.sv
